@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define ASSERT_DIS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// checked on every edge, reset included
`define ASSERT_ALW(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_DIS(label, clk, rst_n, prop)
`define ASSERT_ALW(label, clk, prop)
`endif
`endif

@@ rtl/pfde_pkg.sv @@
// ---------------------------------------------------------------------------
// pfde_pkg
// Shared sizes, operation codes, states and control structs of the engine.
// ---------------------------------------------------------------------------
package pfde_pkg;

    // screen and store geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PIX_PER_BYTE  = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);

    // working coordinate width: covers -257 .. 763
    localparam int COORD_W = 11;

    typedef enum logic [2:0] {
        OP_PIXEL   = 3'd0,
        OP_HRUN    = 3'd1,
        OP_VRUN    = 3'd2,
        OP_RECT    = 3'd3,
        OP_FILL    = 3'd4,
        OP_PATTERN = 3'd5,
        OP_READ    = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEG_INIT,
        S_PIX_RD,
        S_PIX_WR,
        S_SWEEP,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic seg_init;
        logic seg_next;
        logic pix_rd;
        logic pix_wr;
        logic step;
        logic sweep_wr;
        logic rd_issue;
        logic rd_capture;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic run_done;
        logic on_screen;
        logic more_segs;
        logic sweep_last;
    } t_dp_sts;

endpackage

@@ rtl/page_framebuffer_draw_engine.sv @@
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Page-organized monochrome framebuffer with pixel, run, rectangle, fill
// and read-back commands; off-screen pixels are clipped.
// ---------------------------------------------------------------------------
// Each on-screen pixel is a store read, then a write; a clipped pixel is
// stepped over; each segment is set up first. Pattern fill sweeps all bytes;
// read-back issues the read, then captures it. Busy drops the cycle after the
// strobe, so a new command is taken only after the last; the receiver cannot stall.
// Reset: a clearing pass writes zero to all STORE_SIZE (1024) bytes, with
// busy high, then the engine goes idle. Results are one-cycle strobes.
module page_framebuffer_draw_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_operation,
    input  logic signed [8:0] i_pos_x,
    input  logic signed [8:0] i_pos_y,
    input  logic [7:0]        i_extent_w,
    input  logic [7:0]        i_extent_h,
    input  logic              i_ink,
    input  logic [7:0]        i_fill_byte,
    input  logic [9:0]        i_read_address,
    output logic              o_res_valid,
    output logic [7:0]        o_read_data,
    output logic              o_done_res
);

    import pfde_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    pfde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_done_res  (o_done_res)
    );

    // datapath and frame store
    pfde_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_operation    (i_operation),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_extent_w     (i_extent_w),
        .i_extent_h     (i_extent_h),
        .i_ink          (i_ink),
        .i_fill_byte    (i_fill_byte),
        .i_read_address (i_read_address),
        .o_read_data    (o_read_data)
    );

endmodule

@@ rtl/pfde_ram.sv @@
// ---------------------------------------------------------------------------
// pfde_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pfde_dp.sv @@
// ---------------------------------------------------------------------------
// pfde_dp
// Datapath: command registers, run generator, pixel read-modify-write,
// sweep counter and the frame store.
// ---------------------------------------------------------------------------
module pfde_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfde_pkg::t_dp_cmd i_cmd,
    output pfde_pkg::t_dp_sts o_sts,
    input  logic [2:0]        i_operation,
    input  logic signed [8:0] i_pos_x,
    input  logic signed [8:0] i_pos_y,
    input  logic [7:0]        i_extent_w,
    input  logic [7:0]        i_extent_h,
    input  logic              i_ink,
    input  logic [7:0]        i_fill_byte,
    input  logic [9:0]        i_read_address,
    output logic [7:0]        o_read_data
);

    import pfde_pkg::*;

    localparam int AF_W = COORD_W + 9;

    // command registers
    logic [2:0]               r_op;
    logic signed [8:0]        r_x;
    logic signed [8:0]        r_y;
    logic [7:0]               r_w;
    logic [7:0]               r_h;
    logic                     r_ink;
    logic [7:0]               r_pat;
    logic [9:0]               r_raddr;

    // run state
    logic [7:0]               r_seg;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [7:0]               r_len;
    logic [7:0]               r_cnt;
    logic                     r_vert;

    logic [ADDR_W-1:0]        r_sweep;
    logic [7:0]               r_read_data;

    // segment setup
    logic signed [COORD_W-1:0] x_ext, y_ext, w_ext, h_ext, seg_ext;
    logic signed [COORD_W-1:0] seg_x, seg_y;
    logic [7:0]                seg_len;
    logic                      seg_vert;
    logic                      is_rect, is_fill;

    // pixel address
    logic [COORD_W-2:0]        cx_u;
    logic [COORD_W-5:0]        page;
    logic [AF_W-1:0]           addr_full;
    logic [ADDR_W-1:0]         pix_addr;
    logic [7:0]                mask;

    // store port
    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [7:0]                ram_wdata, ram_rdata;
    logic                      rd_in_range;

    // start point, direction and length of the current segment
    always_comb begin
        x_ext    = COORD_W'(r_x);
        y_ext    = COORD_W'(r_y);
        w_ext    = $signed({{(COORD_W-8){1'b0}}, r_w});
        h_ext    = $signed({{(COORD_W-8){1'b0}}, r_h});
        seg_ext  = $signed({{(COORD_W-8){1'b0}}, r_seg});
        is_rect  = (r_op == OP_RECT);
        is_fill  = (r_op == OP_FILL);
        seg_vert = (r_op == OP_VRUN) || (is_rect && r_seg[1]);

        seg_x = x_ext;
        if (is_rect && r_seg[1:0] == 2'd3) begin
            seg_x = x_ext + w_ext - COORD_W'(1);
        end

        seg_y = y_ext;
        if (is_rect && r_seg[1:0] == 2'd1) begin
            seg_y = y_ext + h_ext - COORD_W'(1);
        end else if (is_fill) begin
            seg_y = y_ext + seg_ext;
        end

        if (r_op == OP_PIXEL) begin
            seg_len = 8'd1;
        end else if (is_fill) begin
            seg_len = (r_seg < r_h) ? r_w : 8'd0;
        end else if (seg_vert) begin
            seg_len = r_h;
        end else begin
            seg_len = r_w;
        end
    end

    // clip test, byte address and bit mask of the current pixel
    always_comb begin
        cx_u      = r_cx[COORD_W-2:0];
        page      = r_cy[COORD_W-2:3];
        addr_full = AF_W'(cx_u) + AF_W'(page) * AF_W'(SCREEN_WIDTH);
        pix_addr  = addr_full[ADDR_W-1:0];
        mask      = 8'd1 << r_cy[2:0];

        o_sts.on_screen  = !r_cx[COORD_W-1] && !r_cy[COORD_W-1]
                        && (cx_u < (COORD_W-1)'(SCREEN_WIDTH))
                        && (r_cy[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));
        o_sts.run_done   = (r_cnt == r_len);
        o_sts.sweep_last = (r_sweep == ADDR_W'(STORE_SIZE - 1));
        if (is_rect) begin
            o_sts.more_segs = (r_seg[1:0] != 2'd3);
        end else if (is_fill) begin
            o_sts.more_segs = (({1'b0, r_seg} + 9'd1) < {1'b0, r_h});
        end else begin
            o_sts.more_segs = 1'b0;
        end
    end

    // store port muxing
    always_comb begin
        rd_in_range = (32'(r_raddr) < STORE_SIZE);
        ram_we      = i_cmd.pix_wr | i_cmd.sweep_wr;
        ram_waddr   = i_cmd.sweep_wr ? r_sweep : pix_addr;
        ram_wdata   = i_cmd.sweep_wr ? r_pat
                    : (r_ink ? (ram_rdata | mask) : (ram_rdata & ~mask));
        ram_re      = i_cmd.pix_rd | i_cmd.rd_issue;
        ram_raddr   = i_cmd.rd_issue ? ADDR_W'(r_raddr) : pix_addr;
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_w     <= i_extent_w;
            r_h     <= i_extent_h;
            r_ink   <= i_ink;
            r_raddr <= i_read_address;
        end
    end

    // run generator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seg <= 8'd0;
        end else if (i_cmd.seg_next) begin
            r_seg <= r_seg + 8'd1;
        end

        if (i_cmd.seg_init) begin
            r_cx   <= seg_x;
            r_cy   <= seg_y;
            r_len  <= seg_len;
            r_cnt  <= 8'd0;
            r_vert <= seg_vert;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 8'd1;
            if (r_vert) begin
                r_cy <= r_cy + COORD_W'(1);
            end else begin
                r_cx <= r_cx + COORD_W'(1);
            end
        end
    end

    // fill byte and sweep address; reset gives the zero clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat   <= 8'd0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pat   <= i_fill_byte;
                r_sweep <= '0;
            end else if (i_cmd.sweep_wr) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
        end
    end

    // read-back result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_read_data <= 8'd0;
        end else if (i_cmd.rd_capture) begin
            r_read_data <= rd_in_range ? ram_rdata : 8'd0;
        end
    end

    assign o_read_data = r_read_data;

    pfde_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

@@ rtl/pfde_ctrl.sv @@
// ---------------------------------------------------------------------------
// pfde_ctrl
// Controller: sequences clearing, segments, pixel read-modify-write,
// pattern sweep and read-back, and issues the result strobe.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfde_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_operation,
    output pfde_pkg::t_dp_cmd o_cmd,
    input  pfde_pkg::t_dp_sts i_sts,
    output logic              o_res_valid,
    output logic              o_done_res
);

    import pfde_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_operation)
                        OP_PIXEL, OP_HRUN, OP_VRUN, OP_RECT, OP_FILL: begin
                            n_state = S_SEG_INIT;
                        end
                        OP_PATTERN: n_state = S_SWEEP;
                        OP_READ:    n_state = S_RD_ADDR;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SEG_INIT: begin
                o_cmd.seg_init = 1'b1;
                n_state        = S_PIX_RD;
            end
            S_PIX_RD: begin
                priority if (i_sts.run_done) begin
                    if (i_sts.more_segs) begin
                        o_cmd.seg_next = 1'b1;
                        n_state        = S_SEG_INIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.on_screen) begin
                    o_cmd.pix_rd = 1'b1;
                    n_state      = S_PIX_WR;
                end else begin
                    // clipped pixel: skip it
                    o_cmd.step = 1'b1;
                end
            end
            S_PIX_WR: begin
                o_cmd.pix_wr = 1'b1;
                o_cmd.step   = 1'b1;
                n_state      = S_PIX_RD;
            end
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD_ADDR: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_done_res  = (r_state == S_DONE);

    // checks
    `ASSERT_ALW(a_busy_after_reset, i_clk, !i_rst_n |=> busy)
    `ASSERT_DIS(a_accept_goes_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_DIS(a_strobe_single, i_clk, i_rst_n, o_res_valid |=> !o_res_valid)
    `ASSERT_DIS(a_write_on_screen, i_clk, i_rst_n, o_cmd.pix_wr |-> i_sts.on_screen)
    `ASSERT_DIS(a_sweep_alone, i_clk, i_rst_n, o_cmd.sweep_wr |-> !o_cmd.pix_wr)

endmodule
